// ===== hw/rtl/bacg_pkg.sv =====
// bacg_pkg: transaction types and fixed widths for the bond angle cosine core
// no dependencies; imported by bond_angle_cosine_gradient_core and its testbench
`default_nettype none

package bacg_pkg;

    localparam int POS_W  = 20;
    localparam int COS_W  = 16;
    localparam int GRAD_W = 24;

    // input transaction: two end atoms and the vertex, signed Q10.10
    typedef struct packed {
        logic signed [POS_W-1:0] a_x;
        logic signed [POS_W-1:0] a_y;
        logic signed [POS_W-1:0] a_z;
        logic signed [POS_W-1:0] b_x;
        logic signed [POS_W-1:0] b_y;
        logic signed [POS_W-1:0] b_z;
        logic signed [POS_W-1:0] c_x;
        logic signed [POS_W-1:0] c_y;
        logic signed [POS_W-1:0] c_z;
    } t_in;

    // result transaction: cosine Q1.15, gradients Q8.16, zero-length flag
    typedef struct packed {
        logic signed [COS_W-1:0]  cosine;
        logic signed [GRAD_W-1:0] grad_a_x;
        logic signed [GRAD_W-1:0] grad_a_y;
        logic signed [GRAD_W-1:0] grad_a_z;
        logic signed [GRAD_W-1:0] grad_b_x;
        logic signed [GRAD_W-1:0] grad_b_y;
        logic signed [GRAD_W-1:0] grad_b_z;
        logic                     degenerate;
    } t_out;

endpackage

`default_nettype wire

// ===== hw/rtl/bond_angle_cosine_gradient_core.sv =====
// bond_angle_cosine_gradient_core: pipelined cosine of angle A-C-B and its gradients
// depends on bacg_pkg (transaction types)
//
//  channel  | ports                 | direction | handshake
//  ---------+-----------------------+-----------+------------------------------
//  command  | start, busy, i_data   | in        | taken when start && !busy
//  result   | o_strobe, o_result    | out       | one cycle strobe, no back-pressure
//
// one transaction may enter every cycle; the result strobe rises after the 31-step square root,
// the 31-step unit-vector divide and the 23-step gradient divide, one restoring step per
// register stage.
// busy is always low: the receiver cannot stall, so the pipeline never holds.
// reset clears the valid chain only; no result appears for transactions lost to reset.
`default_nettype none

module bond_angle_cosine_gradient_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  bacg_pkg::t_in   i_data,
    output logic            o_strobe,
    output bacg_pkg::t_out  o_result
);
    import bacg_pkg::*;

    localparam int SQ_STEPS = 31;
    localparam int DV_STEPS = 31;
    localparam int GD_STEPS = 23;
    localparam int SQ_END   = 2 + SQ_STEPS;
    localparam int LAT      = 3 + SQ_STEPS + 1 + DV_STEPS + 1 + 7 + GD_STEPS + 1;

    // valid chain
    logic [LAT-1:0] r_vld;

    // arms and squares
    logic signed [20:0] n_d  [0:1][0:2];
    logic signed [20:0] r_d  [0:1][0:2];
    logic signed [20:0] r_d2 [0:1][0:2];
    logic signed [41:0] n_sq [0:1][0:2];
    logic [40:0]        r_sq [0:1][0:2];
    logic [41:0]        n_n  [0:1];

    // square root pipeline
    logic [41:0]        r_sq_n    [0:SQ_STEPS][0:1];
    logic [32:0]        r_sq_rem  [0:SQ_STEPS][0:1];
    logic [30:0]        r_sq_root [0:SQ_STEPS][0:1];
    logic signed [20:0] r_sq_d    [0:SQ_STEPS][0:1][0:2];
    logic               r_sq_deg  [0:SQ_STEPS];
    logic [32:0]        n_sq_rem  [1:SQ_STEPS][0:1];
    logic [30:0]        n_sq_root [1:SQ_STEPS][0:1];

    // unit-vector divide pipeline
    logic [31:0]        r_dv_rem [0:DV_STEPS][0:1][0:2];
    logic [30:0]        r_dv_q   [0:DV_STEPS][0:1][0:2];
    logic               r_dv_neg [0:DV_STEPS][0:1][0:2];
    logic [30:0]        r_dv_s   [0:DV_STEPS][0:1];
    logic               r_dv_deg [0:DV_STEPS];
    logic [31:0]        n_dv_rem [1:DV_STEPS][0:1][0:2];
    logic [30:0]        n_dv_q   [1:DV_STEPS][0:1][0:2];
    logic [20:0]        n_dmag   [0:1][0:2];

    // cosine and gradient numerator stages
    logic signed [31:0] r_mu   [0:5][0:1][0:2];
    logic [30:0]        r_ms   [0:6][0:1];
    logic               r_mdeg [0:6];
    logic signed [63:0] r_pab  [0:2];
    logic signed [63:0] r_sum;
    logic signed [31:0] r_c;
    logic signed [63:0] r_pu   [0:1][0:2];
    logic signed [32:0] r_r    [0:1][0:2];
    logic [32:0]        r_wmag [0:1][0:2];
    logic               r_wneg [0:1][0:2];
    logic signed [15:0] r_mcos [0:2];
    logic signed [31:0] n_u    [0:1][0:2];
    logic signed [63:0] n_sum;
    logic signed [31:0] n_c;
    logic signed [15:0] n_cos;
    logic signed [63:0] n_pu   [0:1][0:2];
    logic signed [32:0] n_r    [0:1][0:2];
    logic signed [33:0] n_w    [0:1][0:2];

    // gradient divide pipeline
    logic [30:0]        r_gd_rem  [0:GD_STEPS][0:1][0:2];
    logic [22:0]        r_gd_feed [0:GD_STEPS][0:1][0:2];
    logic [22:0]        r_gd_q    [0:GD_STEPS][0:1][0:2];
    logic               r_gd_neg  [0:GD_STEPS][0:1][0:2];
    logic               r_gd_ovf  [0:GD_STEPS][0:1][0:2];
    logic [30:0]        r_gd_s    [0:GD_STEPS][0:1];
    logic               r_gd_deg  [0:GD_STEPS];
    logic signed [15:0] r_gd_cos  [0:GD_STEPS];
    logic [31:0]        n_gd_rem  [1:GD_STEPS][0:1][0:2];
    logic [22:0]        n_gd_q    [1:GD_STEPS][0:1][0:2];
    logic [39:0]        n_gnum    [0:1][0:2];

    // output
    logic signed [GRAD_W-1:0] n_grad [0:1][0:2];
    t_out                     n_out;
    t_out                     r_out;

    assign busy     = 1'b0;
    assign o_strobe = r_vld[LAT-1];
    assign o_result = r_out;

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start & ~busy};
        end
    end

    // arm vectors from the command
    always_comb begin
        n_d[0][0] = {i_data.a_x[19], i_data.a_x} - {i_data.c_x[19], i_data.c_x};
        n_d[0][1] = {i_data.a_y[19], i_data.a_y} - {i_data.c_y[19], i_data.c_y};
        n_d[0][2] = {i_data.a_z[19], i_data.a_z} - {i_data.c_z[19], i_data.c_z};
        n_d[1][0] = {i_data.b_x[19], i_data.b_x} - {i_data.c_x[19], i_data.c_x};
        n_d[1][1] = {i_data.b_y[19], i_data.b_y} - {i_data.c_y[19], i_data.c_y};
        n_d[1][2] = {i_data.b_z[19], i_data.b_z} - {i_data.c_z[19], i_data.c_z};
    end

    // squares and squared lengths
    always_comb begin
        for (int j = 0; j < 2; j++) begin
            for (int i = 0; i < 3; i++) begin
                n_sq[j][i] = r_d[j][i] * r_d[j][i];
            end
            n_n[j] = {1'b0, r_sq[j][0]} + {1'b0, r_sq[j][1]} + {1'b0, r_sq[j][2]};
        end
    end

    // square root steps, one result bit per stage
    always_comb begin
        logic [61:0] x;
        logic [1:0]  pair;
        logic [34:0] rem2;
        logic [34:0] trial;
        logic        ge;
        for (int k = 1; k <= SQ_STEPS; k++) begin
            for (int j = 0; j < 2; j++) begin
                x     = {r_sq_n[k-1][j], 20'b0};
                pair  = x[63-2*k -: 2];
                rem2  = {r_sq_rem[k-1][j], pair};
                trial = {2'b00, r_sq_root[k-1][j], 2'b01};
                ge    = (rem2 >= trial);
                n_sq_rem[k][j]  = ge ? 33'(rem2 - trial) : rem2[32:0];
                n_sq_root[k][j] = {r_sq_root[k-1][j][29:0], ge};
            end
        end
    end

    // divide magnitudes of the arm components
    always_comb begin
        for (int j = 0; j < 2; j++) begin
            for (int i = 0; i < 3; i++) begin
                n_dmag[j][i] = r_sq_d[SQ_STEPS][j][i][20] ?
                               21'(-r_sq_d[SQ_STEPS][j][i]) : 21'(r_sq_d[SQ_STEPS][j][i]);
            end
        end
    end

    // unit-vector divide steps: (|d| * 2^40 + s/2) / s, one quotient bit per stage
    always_comb begin
        logic [30:0] half;
        logic [32:0] rem2;
        logic        ge;
        for (int k = 1; k <= DV_STEPS; k++) begin
            for (int j = 0; j < 2; j++) begin
                half = {1'b0, r_dv_s[k-1][j][30:1]};
                for (int i = 0; i < 3; i++) begin
                    rem2 = {r_dv_rem[k-1][j][i], half[31-k]};
                    ge   = (rem2 >= {2'b00, r_dv_s[k-1][j]});
                    n_dv_rem[k][j][i] = ge ? 32'(rem2 - {2'b00, r_dv_s[k-1][j]})
                                           : rem2[31:0];
                    n_dv_q[k][j][i]   = {r_dv_q[k-1][j][i][29:0], ge};
                end
            end
        end
    end

    // signed unit vectors
    always_comb begin
        for (int j = 0; j < 2; j++) begin
            for (int i = 0; i < 3; i++) begin
                n_u[j][i] = r_dv_neg[DV_STEPS][j][i] ? -$signed({1'b0, r_dv_q[DV_STEPS][j][i]})
                                                     :  $signed({1'b0, r_dv_q[DV_STEPS][j][i]});
            end
        end
    end

    // dot product sum, cosine rounding and clamping
    always_comb begin
        logic [63:0] smag;
        logic [33:0] cm;
        logic [31:0] cmag;
        logic [16:0] om;
        n_sum = r_pab[0] + r_pab[1] + r_pab[2];
        smag  = r_sum[63] ? 64'(-r_sum) : 64'(r_sum);
        cm    = 34'((smag + 64'(1 << 29)) >> 30);
        if (cm > 34'(1 << 30)) begin
            cm = 34'(1 << 30);
        end
        n_c  = r_sum[63] ? -$signed(cm[31:0]) : $signed(cm[31:0]);
        cmag = r_c[31] ? 32'(-r_c) : 32'(r_c);
        om   = 17'((cmag + 32'(1 << 14)) >> 15);
        if (r_c[31]) begin
            n_cos = 16'(-$signed({1'b0, om}));
        end else begin
            n_cos = (om > 17'd32767) ? 16'sd32767 : $signed(om[15:0]);
        end
    end

    // products with the cosine, rounding, and gradient numerators
    always_comb begin
        logic [63:0] pm;
        logic [32:0] rm;
        for (int j = 0; j < 2; j++) begin
            for (int i = 0; i < 3; i++) begin
                n_pu[j][i] = r_mu[3][j][i] * r_c;
                pm         = r_pu[j][i][63] ? 64'(-r_pu[j][i]) : 64'(r_pu[j][i]);
                rm         = 33'((pm + 64'(1 << 29)) >> 30);
                n_r[j][i]  = r_pu[j][i][63] ? -$signed(rm) : $signed(rm);
                n_w[j][i]  = {{2{r_mu[5][1-j][i][31]}}, r_mu[5][1-j][i]}
                             - {r_r[j][i][32], r_r[j][i]};
                n_gnum[j][i] = {1'b0, r_wmag[j][i], 6'b0} + {9'b0, 1'b0, r_ms[6][j][30:1]};
            end
        end
    end

    // gradient divide steps: (|w| * 64 + s/2) / s, one quotient bit per stage
    always_comb begin
        logic [31:0] rem2;
        logic        ge;
        for (int k = 1; k <= GD_STEPS; k++) begin
            for (int j = 0; j < 2; j++) begin
                for (int i = 0; i < 3; i++) begin
                    rem2 = {r_gd_rem[k-1][j][i], r_gd_feed[k-1][j][i][23-k]};
                    ge   = (rem2 >= {1'b0, r_gd_s[k-1][j]});
                    n_gd_rem[k][j][i] = ge ? (rem2 - {1'b0, r_gd_s[k-1][j]}) : rem2;
                    n_gd_q[k][j][i]   = {r_gd_q[k-1][j][i][21:0], ge};
                end
            end
        end
    end

    // signed gradients, saturated to the Q8.16 limits when the quotient overflows
    always_comb begin
        for (int j = 0; j < 2; j++) begin
            for (int i = 0; i < 3; i++) begin
                if (r_gd_ovf[GD_STEPS][j][i]) begin
                    n_grad[j][i] = r_gd_neg[GD_STEPS][j][i] ? {1'b1, 23'b0}
                                                            : {1'b0, {23{1'b1}}};
                end else begin
                    n_grad[j][i] = r_gd_neg[GD_STEPS][j][i]
                                   ? -$signed({1'b0, r_gd_q[GD_STEPS][j][i]})
                                   :  $signed({1'b0, r_gd_q[GD_STEPS][j][i]});
                end
            end
        end
    end

    // result word; for a zero-length arm all fields are zero and only the degenerate flag is set
    always_comb begin
        n_out = '0;
        if (r_gd_deg[GD_STEPS]) begin
            n_out.degenerate = 1'b1;
        end else begin
            n_out.cosine   = r_gd_cos[GD_STEPS];
            n_out.grad_a_x = n_grad[0][0];
            n_out.grad_a_y = n_grad[0][1];
            n_out.grad_a_z = n_grad[0][2];
            n_out.grad_b_x = n_grad[1][0];
            n_out.grad_b_y = n_grad[1][1];
            n_out.grad_b_z = n_grad[1][2];
        end
    end

    // datapath registers, free running
    always_ff @(posedge i_clk) begin
        // arms, squares, lengths
        r_d  <= n_d;
        r_d2 <= r_d;
        for (int j = 0; j < 2; j++) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[j][i] <= n_sq[j][i][40:0];
            end
            r_sq_n[0][j]    <= n_n[j];
            r_sq_rem[0][j]  <= '0;
            r_sq_root[0][j] <= '0;
        end
        r_sq_d[0]   <= r_d2;
        r_sq_deg[0] <= (n_n[0] == '0) || (n_n[1] == '0);

        // square root stages
        for (int k = 1; k <= SQ_STEPS; k++) begin
            r_sq_n[k]    <= r_sq_n[k-1];
            r_sq_d[k]    <= r_sq_d[k-1];
            r_sq_deg[k]  <= r_sq_deg[k-1];
            r_sq_rem[k]  <= n_sq_rem[k];
            r_sq_root[k] <= n_sq_root[k];
        end

        // divide setup: remainder starts at |d| * 2^9
        for (int j = 0; j < 2; j++) begin
            r_dv_s[0][j] <= r_sq_root[SQ_STEPS][j];
            for (int i = 0; i < 3; i++) begin
                r_dv_rem[0][j][i] <= {2'b00, n_dmag[j][i], 9'b0};
                r_dv_q[0][j][i]   <= '0;
                r_dv_neg[0][j][i] <= r_sq_d[SQ_STEPS][j][i][20];
            end
        end
        r_dv_deg[0] <= r_sq_deg[SQ_STEPS];

        // unit-vector divide stages
        for (int k = 1; k <= DV_STEPS; k++) begin
            r_dv_rem[k] <= n_dv_rem[k];
            r_dv_q[k]   <= n_dv_q[k];
            r_dv_neg[k] <= r_dv_neg[k-1];
            r_dv_s[k]   <= r_dv_s[k-1];
            r_dv_deg[k] <= r_dv_deg[k-1];
        end

        // unit vectors and cosine stages
        r_mu[0]   <= n_u;
        r_ms[0]   <= r_dv_s[DV_STEPS];
        r_mdeg[0] <= r_dv_deg[DV_STEPS];
        for (int k = 1; k <= 5; k++) begin
            r_mu[k] <= r_mu[k-1];
        end
        for (int k = 1; k <= 6; k++) begin
            r_ms[k]   <= r_ms[k-1];
            r_mdeg[k] <= r_mdeg[k-1];
        end
        for (int i = 0; i < 3; i++) begin
            r_pab[i] <= r_mu[0][0][i] * r_mu[0][1][i];
        end
        r_sum     <= n_sum;
        r_c       <= n_c;
        r_pu      <= n_pu;
        r_mcos[0] <= n_cos;
        r_mcos[1] <= r_mcos[0];
        r_mcos[2] <= r_mcos[1];
        r_r       <= n_r;
        for (int j = 0; j < 2; j++) begin
            for (int i = 0; i < 3; i++) begin
                r_wneg[j][i] <= n_w[j][i][33];
                r_wmag[j][i] <= n_w[j][i][33] ? 33'(-n_w[j][i]) : n_w[j][i][32:0];
            end
        end

        // gradient divide setup; a quotient of 2^23 or more saturates
        for (int j = 0; j < 2; j++) begin
            r_gd_s[0][j] <= r_ms[6][j];
            for (int i = 0; i < 3; i++) begin
                r_gd_rem[0][j][i]  <= {14'b0, n_gnum[j][i][39:23]};
                r_gd_feed[0][j][i] <= n_gnum[j][i][22:0];
                r_gd_q[0][j][i]    <= '0;
                r_gd_neg[0][j][i]  <= r_wneg[j][i];
                r_gd_ovf[0][j][i]  <= ({14'b0, n_gnum[j][i][39:23]} >= r_ms[6][j]);
            end
        end
        r_gd_deg[0] <= r_mdeg[6];
        r_gd_cos[0] <= r_mcos[2];

        // gradient divide stages; remainder stays below s unless the quotient overflows
        for (int k = 1; k <= GD_STEPS; k++) begin
            for (int j = 0; j < 2; j++) begin
                for (int i = 0; i < 3; i++) begin
                    r_gd_rem[k][j][i] <= n_gd_rem[k][j][i][30:0];
                end
            end
            r_gd_feed[k] <= r_gd_feed[k-1];
            r_gd_q[k]    <= n_gd_q[k];
            r_gd_neg[k]  <= r_gd_neg[k-1];
            r_gd_ovf[k]  <= r_gd_ovf[k-1];
            r_gd_s[k]    <= r_gd_s[k-1];
            r_gd_deg[k]  <= r_gd_deg[k-1];
            r_gd_cos[k]  <= r_gd_cos[k-1];
        end

        // result register
        r_out <= n_out;
    end

    // a result strobe always traces back to a command a fixed latency earlier
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, LAT))
        else $error("result strobe without matching command");

    // a nonzero squared length gives a nonzero root
    a_root_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[SQ_END] && !r_sq_deg[SQ_STEPS]) |->
        ((r_sq_root[SQ_STEPS][0] != '0) && (r_sq_root[SQ_STEPS][1] != '0)))
        else $error("zero root for a nondegenerate arm");

    // a degenerate result carries only zeros
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.degenerate) |->
        ((o_result.cosine == '0) && (o_result.grad_a_x == '0) && (o_result.grad_a_y == '0)
         && (o_result.grad_a_z == '0) && (o_result.grad_b_x == '0)
         && (o_result.grad_b_y == '0) && (o_result.grad_b_z == '0)))
        else $error("degenerate result with nonzero fields");

endmodule

`default_nettype wire

// ===== sim/tb_bond_angle_cosine_gradient_core.sv =====
// tb_bond_angle_cosine_gradient_core: self-checking bench for the angle cosine core
// depends on bacg_pkg and bond_angle_cosine_gradient_core
`timescale 1ns / 1ps

// scoreboard: predicts cosine and gradients for each accepted transaction
class angle_scoreboard;
    bacg_pkg::t_out pending[$];
    int mismatches = 0;
    int orphans = 0;

    static function longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    // round half away from zero of v / 2^k
    static function longint shr_rnd(longint v, int k);
        longint m;
        m = (mag(v) + (longint'(1) << (k - 1))) >>> k;
        return v < 0 ? -m : m;
    endfunction

    static function longint div_rnd(longint num, longint den);
        longint m;
        m = (mag(num) + den / 2) / den;
        return num < 0 ? -m : m;
    endfunction

    static function longint clampv(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // floor square root, bitwise restoring
    static function longint root_floor(longint x);
        longint r;
        longint b;
        r = 0;
        b = longint'(1) << 62;
        while (b > x) b = b >>> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic bacg_pkg::t_out predict_angle(bacg_pkg::t_in t);
        bacg_pkg::t_out o;
        longint da[3], db[3], ua[3], ub[3];
        longint na, nb, sa, sb, sum, c, wa, wb;
        longint pa[3], pb[3], pc[3];
        pa = '{longint'(t.a_x), longint'(t.a_y), longint'(t.a_z)};
        pb = '{longint'(t.b_x), longint'(t.b_y), longint'(t.b_z)};
        pc = '{longint'(t.c_x), longint'(t.c_y), longint'(t.c_z)};
        o = '0;
        na = 0;
        nb = 0;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            da[i] = pa[i] - pc[i];
            db[i] = pb[i] - pc[i];
            na += da[i] * da[i];
            nb += db[i] * db[i];
        end
        if (na == 0 || nb == 0) begin
            o.degenerate = 1'b1;
            return o;
        end
        sa = root_floor(na << 20);
        sb = root_floor(nb << 20);
        for (int i = 0; i < 3; i++) begin
            ua[i] = div_rnd(da[i] <<< 40, sa);
            ub[i] = div_rnd(db[i] <<< 40, sb);
            sum += ua[i] * ub[i];
        end
        c = clampv(shr_rnd(sum, 30), -(longint'(1) << 30), longint'(1) << 30);
        o.cosine = 16'(clampv(shr_rnd(c, 15), -32768, 32767));
        for (int i = 0; i < 3; i++) begin
            wa = ub[i] - shr_rnd(ua[i] * c, 30);
            wb = ua[i] - shr_rnd(ub[i] * c, 30);
            pa[i] = clampv(div_rnd(wa * 64, sa), -8388608, 8388607);
            pb[i] = clampv(div_rnd(wb * 64, sb), -8388608, 8388607);
        end
        o.grad_a_x = 24'(pa[0]);
        o.grad_a_y = 24'(pa[1]);
        o.grad_a_z = 24'(pa[2]);
        o.grad_b_x = 24'(pb[0]);
        o.grad_b_y = 24'(pb[1]);
        o.grad_b_z = 24'(pb[2]);
        return o;
    endfunction

    function void note_command(bacg_pkg::t_in t);
        pending.push_back(predict_angle(t));
    endfunction

    function void check_result(bacg_pkg::t_out got);
        bacg_pkg::t_out exp;
        if (pending.size() == 0) begin
            orphans++;
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
        end
        exp = pending.pop_front();
        if (got !== exp) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp cos %0d ga %0d %0d %0d gb %0d %0d %0d dg %0b | got cos %0d ga %0d %0d %0d gb %0d %0d %0d dg %0b",
                    exp.cosine, exp.grad_a_x, exp.grad_a_y, exp.grad_a_z, exp.grad_b_x,
                    exp.grad_b_y, exp.grad_b_z, exp.degenerate, got.cosine, got.grad_a_x,
                    got.grad_a_y, got.grad_a_z, got.grad_b_x, got.grad_b_y, got.grad_b_z,
                    got.degenerate);
        end
    endfunction
endclass

module tb_bond_angle_cosine_gradient_core;
    import bacg_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in i_data;
    logic o_strobe;
    t_out o_result;
    angle_scoreboard board;
    logic gaps_on;

    bond_angle_cosine_gradient_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_data(i_data), .o_strobe(o_strobe), .o_result(o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // generous run limit
    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    // monitor: note accepted commands and check results at rising edges
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) board.note_command(i_data);
            if (o_strobe) board.check_result(o_result);
        end
    end

    function automatic logic [19:0] rand_coord(int mode);
        case (mode)
            0: return 20'($urandom);
            1: return 20'($urandom_range(0, 4095)) - 20'd2048;
            default: return 20'($urandom_range(0, 65535)) - 20'd32768;
        endcase
    endfunction

    // present one command and hold it until accepted
    task automatic send_command(t_in t);
        int g;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            g = $urandom_range(1, 11);
            start <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        start <= 1'b1;
        i_data <= t;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_coords(logic [19:0] ax, logic [19:0] ay, logic [19:0] az,
                               logic [19:0] bx, logic [19:0] by, logic [19:0] bz,
                               logic [19:0] cx, logic [19:0] cy, logic [19:0] cz);
        t_in t;
        t.a_x = ax; t.a_y = ay; t.a_z = az;
        t.b_x = bx; t.b_y = by; t.b_z = bz;
        t.c_x = cx; t.c_y = cy; t.c_z = cz;
        send_command(t);
    endtask

    initial begin
        t_in t;
        int mode;
        int wait_cycles;
        board = new();
        gaps_on = 1'b1;
        start = 1'b0;
        i_data = '0;
        i_rst_n = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: degenerate arms, extremes, right/straight/zero angles, short arms
        send_coords(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_coords(5, 6, 7, 1024, 0, 0, 5, 6, 7);
        send_coords(1024, 0, 0, 3, 3, 3, 3, 3, 3);
        send_coords(1024, 0, 0, 0, 1024, 0, 0, 0, 0);
        send_coords(1024, 0, 0, 2048, 0, 0, 0, 0, 0);
        send_coords(1024, 0, 0, -20'sd1024, 0, 0, 0, 0, 0);
        send_coords(1, 0, 0, 0, 1, 0, 0, 0, 0);
        send_coords(1, 0, 0, 1, 1, 0, 0, 0, 0);
        send_coords(1, 1, 1, -20'sd1, 0, 1, 0, 0, 0);
        send_coords(20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 20'h80000, 20'h80000, 20'h80000,
                    20'h80000, 20'h7FFFF, 20'h80000);
        send_coords(20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 20'h80000, 20'h7FFFF,
                    20'h80000, 20'h80000, 20'h80000);
        send_coords(20'h80000, 20'h80000, 20'h80000, 20'h80000, 20'h7FFFF, 20'h80000,
                    20'h7FFFF, 20'h7FFFF, 20'h7FFFF);
        send_coords(20'hFFFFF, 20'h55555, 20'hAAAAA, 20'h12345, 20'h6789A, 20'hBCDEF,
                    20'h00001, 20'hFFFFE, 20'h40000);
        send_coords(3, 0, 0, 0, 0, 2, 1, 0, 1);
        send_coords(100, 200, 300, 101, 200, 300, 100, 200, 299);

        // random: mostly nearby atoms, some full range, a few degenerate
        for (int n = 0; n < 850; n++) begin
            if (n > 700) gaps_on = 1'b0;
            mode = $urandom_range(0, 2);
            t.c_x = rand_coord(mode); t.c_y = rand_coord(mode); t.c_z = rand_coord(mode);
            t.a_x = t.c_x + rand_coord(mode); t.a_y = t.c_y + rand_coord(mode);
            t.a_z = t.c_z + rand_coord(mode);
            t.b_x = t.c_x + rand_coord(mode); t.b_y = t.c_y + rand_coord(mode);
            t.b_z = t.c_z + rand_coord(mode);
            if ($urandom_range(0, 3) == 0) begin
                t.a_x = t.c_x + 20'($urandom_range(0, 6)) - 20'd3;
                t.a_y = t.c_y + 20'($urandom_range(0, 2)) - 20'd1;
            end
            if ($urandom_range(0, 30) == 0) begin
                t.b_x = t.c_x; t.b_y = t.c_y; t.b_z = t.c_z;
            end
            if ($urandom_range(0, 30) == 0) begin
                t.a_x = t.c_x; t.a_y = t.c_y; t.a_z = t.c_z;
            end
            send_command(t);
        end
        start <= 1'b0;

        // drain the pipeline, then allow extra latency for strays
        wait_cycles = 0;
        while (board.pending.size() != 0 && wait_cycles < 2000) begin
            @(negedge i_clk);
            wait_cycles++;
        end
        repeat (200) @(negedge i_clk);
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
hw/rtl/bacg_pkg.sv
hw/rtl/bond_angle_cosine_gradient_core.sv
sim/tb_bond_angle_cosine_gradient_core.sv
